// ----- design/chd_pkg.sv -----
`default_nettype none

package chd_pkg;

    localparam int unsigned WORD_W       = 16;
    localparam int unsigned INDEX_W      = 6;
    localparam int unsigned COUNT_W      = 7;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned IN_TDATA_W   = 16;
    localparam int unsigned OUT_TDATA_W  = 32;
    localparam int unsigned OUT_TUSER_W  = 3;
    localparam int unsigned DEF_CHANNELS = 64;

    localparam logic [3:0] HEADER_NIBBLE = 4'h1;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_CHAN,
        PH_BEYOND,
        PH_ERROR
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA,
        ST_BAD_HEADER,
        ST_BEYOND,
        ST_AFTER_ERROR
    } status_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        logic               start;
        status_t            status;
        logic [COUNT_W-1:0] seen;
        logic               done;
    } result_t;

endpackage

`default_nettype wire

// ----- design/channel_header_deframer.sv -----
// Channel header deframer for one card's raw readout stream.
// The slave channel takes one 16-bit word per request in s_axis_tdata, with
// s_axis_tlast marking the last word of the card. The master channel returns
// exactly one result per word: the word itself, the channel it belongs to and
// the running channel count in m_axis_tdata, the header-match flag and word
// status in m_axis_tuser, and m_axis_tlast on the card's last word.
// The first word of a card fixes the frame number; in the channel phase every
// word with a top nibble of 1 is checked as the next channel header. A mismatch
// latches an error status until card end, and headers past CHANNELS_PER_CARD
// mark the rest of the card as beyond the last channel.
// An accepted word's result is registered before it appears on the master side.
// Throughput is one word per cycle while the receiver keeps up; the whole
// decision is a single compare and counter update ahead of the result register.
// When the receiver stalls, one more word is held in a skid register, after
// which s_axis_tready drops until the result register drains.
// Reset empties both result registers and returns the block to waiting for
// the first word of a card.
`default_nettype none

module channel_header_deframer #(
    parameter int unsigned CHANNELS_PER_CARD = chd_pkg::DEF_CHANNELS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] data_word
    input  wire logic [chd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [15:0] word_out, [21:16] channel_index, [28:22] channels_seen, [31:29] zero
    output logic [chd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] channel_start, [2:1] word_status
    output logic [chd_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import chd_pkg::*;

    localparam logic [COUNT_W-1:0] CHANNEL_LIMIT = COUNT_W'(CHANNELS_PER_CARD);

    phase_t             phase_reg, phase_next;
    logic [INDEX_W-1:0] frame_reg, frame_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    result_t result_reg, skid_reg, new_result;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic               accept;
    logic               pop;
    logic [WORD_W-1:0]  word;
    logic [INDEX_W-1:0] frame_eff;
    logic [COUNT_W-1:0] count_eff;
    logic [WORD_W-1:0]  expected;
    logic               header_like;
    logic               header_ok;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = out_valid_reg && m_axis_tready;
    assign word          = s_axis_tdata[WORD_W-1:0];

    assign frame_eff   = (phase_reg == PH_FIRST) ? word[11:6] : frame_reg;
    assign count_eff   = (phase_reg == PH_FIRST) ? '0 : count_reg;
    assign expected    = {HEADER_NIBBLE, frame_eff, count_eff[INDEX_W-1:0]};
    assign header_like = (word[15:12] == HEADER_NIBBLE);
    assign header_ok   = (word == expected);

    always_comb
    begin
        phase_next = phase_reg;
        frame_next = frame_reg;
        count_next = count_eff;
        new_result.word   = word;
        new_result.index  = '0;
        new_result.start  = 1'b0;
        new_result.status = ST_DATA;
        new_result.done   = s_axis_tlast;

        unique case (phase_reg)
            PH_FIRST:
            begin
                frame_next       = word[11:6];
                new_result.index = '0;
                if (header_ok)
                begin
                    new_result.start = 1'b1;
                    count_next       = COUNT_W'(1);
                    phase_next       = PH_CHAN;
                end
                else
                begin
                    new_result.status = ST_BAD_HEADER;
                    phase_next        = PH_ERROR;
                end
            end
            PH_CHAN:
            begin
                if (header_like)
                begin
                    if (count_reg >= CHANNEL_LIMIT)
                    begin
                        new_result.status = ST_BEYOND;
                        phase_next        = PH_BEYOND;
                    end
                    else
                    begin
                        new_result.index = count_reg[INDEX_W-1:0];
                        if (header_ok)
                        begin
                            new_result.start = 1'b1;
                            count_next       = count_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            new_result.status = ST_BAD_HEADER;
                            phase_next        = PH_ERROR;
                        end
                    end
                end
                else if (count_reg != '0)
                begin
                    new_result.index = INDEX_W'(count_reg - COUNT_W'(1));
                end
            end
            PH_BEYOND:
            begin
                new_result.status = ST_BEYOND;
            end
            PH_ERROR:
            begin
                new_result.status = ST_AFTER_ERROR;
            end
            default:
            begin
                new_result.status = ST_AFTER_ERROR;
            end
        endcase

        new_result.seen = count_next;

        if (s_axis_tlast)
        begin
            phase_next = PH_FIRST;
            frame_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            frame_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            frame_reg <= frame_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop || !out_valid_reg)
        begin
            out_valid_next  = skid_valid_reg || accept;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
        begin
            result_reg <= skid_valid_reg ? skid_reg : new_result;
        end
        else if (accept)
        begin
            skid_reg <= new_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, result_reg.seen, result_reg.index, result_reg.word};
    assign m_axis_tuser  = {result_reg.status, result_reg.start};
    assign m_axis_tlast  = result_reg.done;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_card_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=> (phase_reg == PH_FIRST && count_reg == '0))
        else $error("card end did not return the deframer to its first-word phase");

    a_first_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FIRST) |-> (count_reg == '0))
        else $error("channel count is nonzero while waiting for a card's first word");

    a_start_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && result_reg.start) |->
            (result_reg.status == ST_DATA && result_reg.seen != '0))
        else $error("channel start flagged on a word that did not open a channel");
`endif

endmodule

`default_nettype wire
